// ----- rtl/core/mfb_pkg.sv -----
package mfb_pkg;

	// default screen geometry
	localparam int DEF_SCREEN_WIDTH = 96;
	localparam int DEF_SCREEN_PAGES = 2;

	// request codes
	localparam logic [3:0] REQ_CLEAR  = 4'd0;
	localparam logic [3:0] REQ_PIXEL  = 4'd1;
	localparam logic [3:0] REQ_HLINE  = 4'd2;
	localparam logic [3:0] REQ_VLINE  = 4'd3;
	localparam logic [3:0] REQ_FILL   = 4'd4;
	localparam logic [3:0] REQ_FRAME  = 4'd5;
	localparam logic [3:0] REQ_LINE   = 4'd6;
	localparam logic [3:0] REQ_RBOX   = 4'd7;
	localparam logic [3:0] REQ_RFRAME = 4'd8;
	localparam logic [3:0] REQ_READ   = 4'd9;

	// index of the last job slot; a command expands into at most LAST_JOB+1 primitive jobs
	localparam logic [2:0] LAST_JOB = 3'd7;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] end_x;
		logic [7:0] end_y;
		logic [7:0] span_w;
		logic [7:0] span_h;
		logic [7:0] radius;
		logic       pixel_on;
		logic [7:0] read_index;
	} mfb_in_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] kind_echo;
	} mfb_out_t;

	typedef enum logic [1:0] {
		J_NONE   = 2'd0,
		J_RECT   = 2'd1,
		J_LINE   = 2'd2,
		J_CORNER = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] x1;
		logic [7:0] y1;
		logic [7:0] r;
		logic [1:0] quad;
		logic       solid;
	} mfb_job_t;

	// one pixel request from the walker
	typedef struct packed {
		logic       valid;
		logic [7:0] x;
		logic [7:0] y;
	} mfb_px_t;

	// requests into the frame store
	typedef struct packed {
		logic       px_valid;
		logic [7:0] px_x;
		logic [7:0] px_y;
		logic       px_on;
		logic       clr_start;
		logic       rd_en;
		logic [7:0] rd_index;
	} mfb_store_req_t;

	typedef struct packed {
		logic       ready;
		logic [7:0] rd_data;
	} mfb_store_st_t;

	function automatic mfb_job_t mk_rect(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h);
		mfb_job_t j;
		j = '0;
		j.kind = J_RECT;
		j.x = x;
		j.y = y;
		j.w = w;
		j.h = h;
		return j;
	endfunction

	// one side of a one-pixel frame, nothing for an empty frame
	function automatic mfb_job_t frame_part(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h, input logic [2:0] idx);
		mfb_job_t j;
		j = '0;
		if (w != 8'd0 && h != 8'd0) begin
			case (idx)
				3'd0: j = mk_rect(x, y, w, 8'd1);
				3'd1: j = mk_rect(x, y + h - 8'd1, w, 8'd1);
				3'd2: j = mk_rect(x, y, 8'd1, h);
				3'd3: j = mk_rect(x + w - 8'd1, y, 8'd1, h);
				default: j = '0;
			endcase
		end
		return j;
	endfunction

	function automatic mfb_job_t mk_corner(input logic [7:0] cx, input logic [7:0] cy,
			input logic [7:0] r, input logic [1:0] quad, input logic solid);
		mfb_job_t j;
		j = '0;
		j.kind = J_CORNER;
		j.x = cx;
		j.y = cy;
		j.r = r;
		j.quad = quad;
		j.solid = solid;
		return j;
	endfunction

	// job list of a drawing command
	function automatic mfb_job_t job_at(input mfb_in_t c, input logic [2:0] idx);
		mfb_job_t j;
		logic [8:0] r2;
		logic fb;
		logic [7:0] inw, inh, xl, xr, yt, yb, cx, cy;
		logic [1:0] q;
		j = '0;
		r2 = {c.radius, 1'b0};
		fb = (c.radius == 8'd0) || ({1'b0, c.span_w} <= r2) || ({1'b0, c.span_h} <= r2);
		inw = c.span_w - r2[7:0];
		inh = c.span_h - r2[7:0];
		xl = c.pos_x + c.radius;
		xr = c.pos_x + c.span_w - c.radius - 8'd1;
		yt = c.pos_y + c.radius;
		yb = c.pos_y + c.span_h - c.radius - 8'd1;
		q = (c.req_type == REQ_RBOX) ? 2'(idx - 3'd3) : idx[1:0];
		cx = q[0] ? xr : xl;
		cy = q[1] ? yb : yt;
		case (c.req_type)
			REQ_PIXEL: if (idx == 3'd0) j = mk_rect(c.pos_x, c.pos_y, 8'd1, 8'd1);
			REQ_HLINE: if (idx == 3'd0) j = mk_rect(c.pos_x, c.pos_y, c.span_w, 8'd1);
			REQ_VLINE: if (idx == 3'd0) j = mk_rect(c.pos_x, c.pos_y, 8'd1, c.span_h);
			REQ_FILL:  if (idx == 3'd0) j = mk_rect(c.pos_x, c.pos_y, c.span_w, c.span_h);
			REQ_FRAME: j = frame_part(c.pos_x, c.pos_y, c.span_w, c.span_h, idx);
			REQ_LINE: begin
				if (idx == 3'd0) begin
					j.kind = J_LINE;
					j.x = c.pos_x;
					j.y = c.pos_y;
					j.x1 = c.end_x;
					j.y1 = c.end_y;
				end
			end
			REQ_RBOX: begin
				if (fb) begin
					if (idx == 3'd0) j = mk_rect(c.pos_x, c.pos_y, c.span_w, c.span_h);
				end else begin
					case (idx)
						3'd0: j = mk_rect(xl, c.pos_y, inw, c.span_h);
						3'd1: j = mk_rect(c.pos_x, yt, c.radius, inh);
						3'd2: j = mk_rect(c.pos_x + c.span_w - c.radius, yt, c.radius, inh);
						3'd7: j = '0;
						default: j = mk_corner(cx, cy, c.radius, q, 1'b1);
					endcase
				end
			end
			REQ_RFRAME: begin
				if (fb) begin
					j = frame_part(c.pos_x, c.pos_y, c.span_w, c.span_h, idx);
				end else begin
					case (idx)
						3'd0: j = mk_rect(xl, c.pos_y, inw, 8'd1);
						3'd1: j = mk_rect(xl, c.pos_y + c.span_h - 8'd1, inw, 8'd1);
						3'd2: j = mk_rect(c.pos_x, yt, 8'd1, inh);
						3'd3: j = mk_rect(c.pos_x + c.span_w - 8'd1, yt, 8'd1, inh);
						default: j = mk_corner(cx, cy, c.radius, q, 1'b0);
					endcase
				end
			end
			default: j = '0;
		endcase
		return j;
	endfunction

endpackage

// ----- rtl/core/mfb_store.sv -----
module mfb_store #(
	parameter int SCREEN_WIDTH = mfb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_PAGES = mfb_pkg::DEF_SCREEN_PAGES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mfb_pkg::mfb_store_req_t req,
	output mfb_pkg::mfb_store_st_t  st
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WR   = 3'b010,
		S_CLR  = 3'b100
	} st_state_t;

	st_state_t      state_q;
	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  waddr_q;
	logic [7:0]     mask_q;
	logic           on_q;
	logic [7:0]     rd_data_q;
	logic [7:0]     mem [DEPTH];

	logic           on_scr;
	logic [31:0]    pix_lin;
	logic [AW-1:0]  pix_addr;
	logic [AW-1:0]  raddr;
	logic           px_acc;

	// pixel address and screen bounds
	assign on_scr = (32'(req.px_x) < 32'(SCREEN_WIDTH)) &&
		(32'(req.px_y) < 32'(8 * SCREEN_PAGES));
	assign pix_lin = 32'(req.px_y[7:3]) * 32'(SCREEN_WIDTH) + 32'(req.px_x);
	assign pix_addr = pix_lin[AW-1:0];
	assign px_acc = req.px_valid && (state_q == S_IDLE);
	assign raddr = req.rd_en ? AW'(req.rd_index) : pix_addr;

	assign st.ready = (state_q == S_IDLE);
	assign st.rd_data = rd_data_q;

	// memory: read every cycle, write back a modified byte or sweep zeros
	always_ff @(posedge clk) begin
		rd_data_q <= mem[raddr];
		if (state_q == S_WR) begin
			mem[waddr_q] <= on_q ? (rd_data_q | mask_q) : (rd_data_q & ~mask_q);
		end else if (state_q == S_CLR) begin
			mem[clr_q] <= 8'd0;
		end
	end

	// pending write-back
	always_ff @(posedge clk) begin
		if (px_acc) begin
			waddr_q <= pix_addr;
			mask_q <= 8'd1 << req.px_y[2:0];
			on_q <= req.px_on;
		end
	end

	// control: clearing pass from reset, pixel read-modify-write interlock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.clr_start) begin
						state_q <= S_CLR;
						clr_q <= '0;
					end else if (px_acc && on_scr) begin
						state_q <= S_WR;
					end
				end
				S_WR: state_q <= S_IDLE;
				S_CLR: begin
					if (clr_q == LAST_ADDR) state_q <= S_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/mfb_walk.sv -----
module mfb_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_start,
	input  mfb_pkg::mfb_job_t job,
	input  logic              px_ready,
	output mfb_pkg::mfb_px_t  px,
	output logic              job_done
);

	typedef enum logic [5:0] {
		W_IDLE = 6'b000001,
		W_RECT = 6'b000010,
		W_LINE = 6'b000100,
		W_CHK  = 6'b001000,
		W_CB   = 6'b010000,
		W_STEP = 6'b100000
	} walk_state_t;

	typedef enum logic [1:0] {
		RET_DONE = 2'd0,
		RET_CB   = 2'd1,
		RET_STEP = 2'd2
	} ret_t;

	walk_state_t state_q;
	ret_t        ret_q;

	// span walker
	logic [7:0] rx_q, ry_q, rw_q, rh_q, rc_q, rr_q;
	// line walker
	logic [7:0] lx_q, ly_q, lx1_q, ly1_q, ldx_q, ldy_q;
	logic       xinc_q, yinc_q;
	logic signed [11:0] err_q;
	// corner walker
	logic [7:0] cx_q, cy_q, cb_q;
	logic [8:0] ca_q;
	logic [1:0] quad_q;
	logic       solid_q;
	logic signed [12:0] cd_q;

	logic        rect_empty, rect_last, line_last, px_acc;
	logic        left, top;
	logic [7:0]  ua, ub, ya, yb, ax, bx, aw, bw;
	logic signed [12:0] e2;
	logic        c1, c2;
	logic [7:0]  jdx, jdy;

	assign rect_empty = (rw_q == 8'd0) || (rh_q == 8'd0);
	assign rect_last = (rc_q == rw_q - 8'd1) && (rr_q == rh_q - 8'd1);
	assign line_last = (lx_q == lx1_q) && (ly_q == ly1_q);

	assign px.valid = ((state_q == W_RECT) && !rect_empty) || (state_q == W_LINE);
	assign px.x = (state_q == W_LINE) ? lx_q : rx_q + rc_q;
	assign px.y = (state_q == W_LINE) ? ly_q : ry_q + rr_q;
	assign px_acc = px.valid && px_ready;

	// the two spans or points of one midpoint step
	assign left = !quad_q[0];
	assign top = !quad_q[1];
	assign ua = ca_q[7:0];
	assign ub = cb_q;
	assign ya = top ? cy_q - ua : cy_q + ua;
	assign yb = top ? cy_q - ub : cy_q + ub;
	assign ax = left ? cx_q - ub : (solid_q ? cx_q : cx_q + ub);
	assign bx = left ? cx_q - ua : (solid_q ? cx_q : cx_q + ua);
	assign aw = solid_q ? ub + 8'd1 : 8'd1;
	assign bw = solid_q ? ua + 8'd1 : 8'd1;

	// bresenham error terms
	assign e2 = 13'(err_q) <<< 1;
	assign c1 = e2 >= -$signed({5'd0, ldy_q});
	assign c2 = e2 <= $signed({5'd0, ldx_q});
	assign jdx = (job.x1 > job.x) ? job.x1 - job.x : job.x - job.x1;
	assign jdy = (job.y1 > job.y) ? job.y1 - job.y : job.y - job.y1;

	always_comb begin
		job_done = 1'b0;
		case (state_q)
			W_RECT: job_done = (ret_q == RET_DONE) && (rect_empty || (px_acc && rect_last));
			W_LINE: job_done = px_acc && line_last;
			W_CHK:  job_done = ({1'b0, cb_q} < ca_q);
			default: job_done = 1'b0;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				if (job_start) begin
					rx_q <= job.x;
					ry_q <= job.y;
					rw_q <= job.w;
					rh_q <= job.h;
					rc_q <= 8'd0;
					rr_q <= 8'd0;
					lx_q <= job.x;
					ly_q <= job.y;
					lx1_q <= job.x1;
					ly1_q <= job.y1;
					ldx_q <= jdx;
					ldy_q <= jdy;
					xinc_q <= job.x < job.x1;
					yinc_q <= job.y < job.y1;
					err_q <= $signed({4'd0, jdx}) - $signed({4'd0, jdy});
					cx_q <= job.x;
					cy_q <= job.y;
					cb_q <= job.r;
					ca_q <= 9'd0;
					quad_q <= job.quad;
					solid_q <= job.solid;
					cd_q <= 13'sd3 - $signed({4'd0, job.r, 1'b0});
				end
			end
			W_RECT: begin
				if (px_acc) begin
					if (rc_q == rw_q - 8'd1) begin
						rc_q <= 8'd0;
						rr_q <= rr_q + 8'd1;
					end else begin
						rc_q <= rc_q + 8'd1;
					end
				end
			end
			W_LINE: begin
				if (px_acc) begin
					if (c1) lx_q <= xinc_q ? lx_q + 8'd1 : lx_q - 8'd1;
					if (c2) ly_q <= yinc_q ? ly_q + 8'd1 : ly_q - 8'd1;
					err_q <= err_q - (c1 ? $signed({4'd0, ldy_q}) : 12'sd0)
						+ (c2 ? $signed({4'd0, ldx_q}) : 12'sd0);
				end
			end
			W_CHK: begin
				rx_q <= ax;
				ry_q <= ya;
				rw_q <= aw;
				rh_q <= 8'd1;
				rc_q <= 8'd0;
				rr_q <= 8'd0;
			end
			W_CB: begin
				rx_q <= bx;
				ry_q <= yb;
				rw_q <= bw;
				rh_q <= 8'd1;
				rc_q <= 8'd0;
				rr_q <= 8'd0;
			end
			W_STEP: begin
				if (cd_q < 0) begin
					cd_q <= cd_q + $signed({2'd0, ca_q, 2'd0}) + 13'sd6;
				end else begin
					cd_q <= cd_q + (($signed({4'd0, ca_q}) - $signed({5'd0, cb_q})) <<< 2)
						+ 13'sd10;
					cb_q <= cb_q - 8'd1;
				end
				ca_q <= ca_q + 9'd1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			ret_q <= RET_DONE;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (job_start) begin
						ret_q <= RET_DONE;
						case (job.kind)
							mfb_pkg::J_RECT:   state_q <= W_RECT;
							mfb_pkg::J_LINE:   state_q <= W_LINE;
							mfb_pkg::J_CORNER: state_q <= W_CHK;
							default:           state_q <= W_IDLE;
						endcase
					end
				end
				W_RECT: begin
					if (rect_empty || (px_acc && rect_last)) begin
						case (ret_q)
							RET_CB:   state_q <= W_CB;
							RET_STEP: state_q <= W_STEP;
							default:  state_q <= W_IDLE;
						endcase
					end
				end
				W_LINE: if (px_acc && line_last) state_q <= W_IDLE;
				W_CHK: begin
					if ({1'b0, cb_q} < ca_q) begin
						state_q <= W_IDLE;
					end else begin
						ret_q <= RET_CB;
						state_q <= W_RECT;
					end
				end
				W_CB: begin
					ret_q <= RET_STEP;
					state_q <= W_RECT;
				end
				W_STEP: state_q <= W_CHK;
				default: state_q <= W_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/mono_framebuffer_raster_engine.sv -----
// Drawing engine over a page-organised monochrome framebuffer. A command is
// taken when start is high and busy is low; when it completes, done pulses for
// exactly one cycle with the result, and the receiver cannot hold it off. The
// time per command is set by the frame store: an on-screen pixel costs a read
// and a write-back, an off-screen pixel only the read; each of the eight job
// slots is visited, each corner step passes W_CHK, W_CB and W_STEP, and the
// end waits for the last write-back. Clear sweeps the store one byte a cycle,
// all SCREEN_WIDTH*SCREEN_PAGES bytes (192 by default); the same pass runs
// after reset, during which busy is high. A read passes the store's read
// register and the result register; unknown request types are answered
// straight from idle. The next command can be taken in the cycle that done shows.
module mono_framebuffer_raster_engine #(
	parameter int SCREEN_WIDTH = mfb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_PAGES = mfb_pkg::DEF_SCREEN_PAGES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mfb_pkg::mfb_in_t  req,
	output logic              done,
	output mfb_pkg::mfb_out_t result
);

	localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_PAGES;

	typedef enum logic [6:0] {
		T_WIPE  = 7'b0000001,
		T_IDLE  = 7'b0000010,
		T_CLR   = 7'b0000100,
		T_JOB   = 7'b0001000,
		T_WAIT  = 7'b0010000,
		T_DRAIN = 7'b0100000,
		T_READ  = 7'b1000000
	} top_state_t;

	top_state_t              state_q;
	logic [2:0]              idx_q;
	logic                    done_q;
	mfb_pkg::mfb_out_t       result_q;
	mfb_pkg::mfb_in_t        cmd_q;
	logic                    rng_q;

	logic                    accept;
	mfb_pkg::mfb_job_t       job;
	logic                    job_start;
	logic                    wk_done;
	mfb_pkg::mfb_px_t        px;
	mfb_pkg::mfb_store_req_t st_req;
	mfb_pkg::mfb_store_st_t  st;

	assign accept = start && !busy;
	assign busy = (state_q != T_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign job = mfb_pkg::job_at(cmd_q, idx_q);
	assign job_start = (state_q == T_JOB) && (job.kind != mfb_pkg::J_NONE);

	// store request group
	assign st_req.px_valid = px.valid;
	assign st_req.px_x = px.x;
	assign st_req.px_y = px.y;
	assign st_req.px_on = cmd_q.pixel_on;
	assign st_req.clr_start = accept && (req.req_type == mfb_pkg::REQ_CLEAR);
	assign st_req.rd_en = accept && (req.req_type == mfb_pkg::REQ_READ);
	assign st_req.rd_index = req.read_index;

	mfb_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_start(job_start),
		.job      (job),
		.px_ready (st.ready),
		.px       (px),
		.job_done (wk_done)
	);

	mfb_store #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_PAGES(SCREEN_PAGES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (st_req),
		.st    (st)
	);

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
			rng_q <= {24'd0, req.read_index} < 32'(STORE_SIZE);
		end
	end

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_WIPE;
			idx_q <= 3'd0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				T_WIPE: if (st.ready) state_q <= T_IDLE;
				T_IDLE: begin
					if (accept) begin
						idx_q <= 3'd0;
						case (req.req_type) inside
							mfb_pkg::REQ_CLEAR: state_q <= T_CLR;
							[mfb_pkg::REQ_PIXEL:mfb_pkg::REQ_RFRAME]: state_q <= T_JOB;
							mfb_pkg::REQ_READ: state_q <= T_READ;
							default: begin
								done_q <= 1'b1;
								result_q <= '{byte_value: 8'd0, kind_echo: req.req_type};
							end
						endcase
					end
				end
				T_CLR: begin
					if (st.ready) begin
						done_q <= 1'b1;
						result_q <= '{byte_value: 8'd0, kind_echo: cmd_q.req_type};
						state_q <= T_IDLE;
					end
				end
				T_JOB: begin
					if (job.kind != mfb_pkg::J_NONE) state_q <= T_WAIT;
					else if (idx_q == mfb_pkg::LAST_JOB) state_q <= T_DRAIN;
					else idx_q <= idx_q + 3'd1;
				end
				T_WAIT: begin
					if (wk_done) begin
						if (idx_q == mfb_pkg::LAST_JOB) begin
							state_q <= T_DRAIN;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= T_JOB;
						end
					end
				end
				T_DRAIN: begin
					// last write-back must land before the next command
					if (st.ready) begin
						done_q <= 1'b1;
						result_q <= '{byte_value: 8'd0, kind_echo: cmd_q.req_type};
						state_q <= T_IDLE;
					end
				end
				T_READ: begin
					done_q <= 1'b1;
					result_q <= '{byte_value: (rng_q ? st.rd_data : 8'd0),
						kind_echo: cmd_q.req_type};
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/mfb_checker.sv -----
module mfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input mfb_pkg::mfb_in_t  req,
	input logic              done,
	input mfb_pkg::mfb_out_t result
);

	// a result always leaves the block ready for the next command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// every known command leaves the block busy in the cycle after it is taken
	a_known_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type <= mfb_pkg::REQ_READ) |=> busy)
		else $error("known command not held busy");

	// unknown commands are acknowledged at once with their own type
	a_unknown_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type > mfb_pkg::REQ_READ) |=>
		(done && result.kind_echo == $past(req.req_type) && result.byte_value == 8'd0))
		else $error("unknown command not acknowledged");

	// only a read returns data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.kind_echo != mfb_pkg::REQ_READ) |-> result.byte_value == 8'd0)
		else $error("non-read result carries data");

endmodule

bind mono_framebuffer_raster_engine mfb_checker u_mfb_checker (.*);
